// ===== hw/rtl/ans_pkg.sv =====
// ans_pkg: shared constants and types for the annex b nal splitter
// no dependencies; used by the interfaces, the scanner and the top level

package ans_pkg;

  localparam int POSITION_BITS = 32;
  localparam int WORD_BITS     = 32;
  localparam int FIELD6_BITS   = 6;

  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] BYTE_ONE   = 8'h01;
  localparam logic [1:0] ZERO_RUN_MAX = 2'd3;
  localparam logic [1:0] ZERO_RUN_CODE = 2'd2;

  typedef logic [POSITION_BITS-1:0] pos_t;

  localparam pos_t POS_MAX = {POSITION_BITS{1'b1}};

  typedef struct packed {
    logic [WORD_BITS-1:0]   unit_offset;
    logic [WORD_BITS-1:0]   unit_length;
    logic [FIELD6_BITS-1:0] unit_type;
    logic [FIELD6_BITS-1:0] layer_num;
    logic                   stream_final;
  } result_t;

  function automatic pos_t pos_inc(input pos_t p);
    pos_inc = (p == POS_MAX) ? p : p + pos_t'(1);
  endfunction

endpackage

// ===== hw/rtl/ans_ifs.sv =====
// ans_ifs: valid/ready channel interfaces for the byte input and the unit result
// depends on ans_pkg

interface ans_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_last;

  modport source (output valid, output data_byte, output stream_last, input ready);
  modport sink   (input valid, input data_byte, input stream_last, output ready);
endinterface

interface ans_out_if;
  logic                               valid;
  logic                               ready;
  logic [ans_pkg::WORD_BITS-1:0]      unit_offset;
  logic [ans_pkg::WORD_BITS-1:0]      unit_length;
  logic [ans_pkg::FIELD6_BITS-1:0]    unit_type;
  logic [ans_pkg::FIELD6_BITS-1:0]    layer_num;
  logic                               stream_final;

  modport source (output valid, output unit_offset, output unit_length, output unit_type,
                  output layer_num, output stream_final, input ready);
  modport sink   (input valid, input unit_offset, input unit_length, input unit_type,
                  input layer_num, input stream_final, output ready);
endinterface

// ===== hw/rtl/annex_b_nal_splitter.sv =====
// annex_b_nal_splitter: top level, scanner plus output register with skid stage
// depends on ans_pkg, ans_ifs and ans_scanner
//
// usage:
//   in_chan carries one stream byte per word (data_byte, stream_last); a word is
//   taken when valid and ready are both high. out_chan carries one word per
//   unit found: payload offset and length, nal type, layer id and a flag set
//   when the unit was closed by the stream's last byte.
//   throughput: one input byte per cycle, sustained while out_chan keeps up.
//   output: a result is registered, into the output register or, when that holds
//   a stalled word, into the skid stage, as the byte that closes its unit is taken.
//   the output register is backed by a one-word skid stage; in_chan.ready is
//   a register output and drops only when that skid stage holds a word, so a
//   stalled receiver holds off the input after at most two pending results.
//   reset (rst_n low, synchronous) clears the position counter, the scanner
//   state and both output stages; the byte after reset is position zero.
//   after a byte marked stream_last the scanner is back in its reset state.

module annex_b_nal_splitter (
  input  logic       clk,
  input  logic       rst_n,
  ans_in_if.sink     in_chan,
  ans_out_if.source  out_chan
);

  logic             accept;
  logic             res_valid;
  ans_pkg::result_t res;

  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  ans_pkg::result_t out_data_r, out_data_nxt;
  ans_pkg::result_t skid_data_r, skid_data_nxt;
  logic             pop, push;

  assign in_chan.ready = !skid_valid_r;
  assign accept        = in_chan.valid && in_chan.ready;

  ans_scanner u_scanner (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_chan.data_byte),
    .stream_last (in_chan.stream_last),
    .res_valid   (res_valid),
    .res         (res)
  );

  assign pop  = out_valid_r && out_chan.ready;
  assign push = res_valid;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (pop) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = res;
      end
    end else if (push) begin
      if (!out_valid_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.unit_offset  = out_data_r.unit_offset;
  assign out_chan.unit_length  = out_data_r.unit_length;
  assign out_chan.unit_type    = out_data_r.unit_type;
  assign out_chan.layer_num    = out_data_r.layer_num;
  assign out_chan.stream_final = out_data_r.stream_final;

  // skid stage is only ever filled behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word without output word");

  // a new result arriving at a stalled full output lands in the skid stage
  a_push_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_valid_r && !out_chan.ready) |=> skid_valid_r)
    else $error("result lost while output stalled");

  // draining the skid stage moves its word into the output register
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && skid_valid_r) |=> (out_valid_r && !skid_valid_r && out_data_r == $past(skid_data_r)))
    else $error("skid word not forwarded");

endmodule

// ===== hw/rtl/ans_scanner.sv =====
// ans_scanner: start code scanner state and per-word unit result logic
// depends on ans_pkg

module ans_scanner (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             stream_last,
  output logic             res_valid,
  output ans_pkg::result_t res
);

  ans_pkg::pos_t pos_r, pos_nxt;
  ans_pkg::pos_t begin_r, begin_nxt;
  logic [1:0]    zero_run_r, zero_run_nxt;
  logic          open_r, open_nxt;
  logic [7:0]    hdr_first_r, hdr_first_nxt;
  logic [7:0]    hdr_second_r, hdr_second_nxt;

  logic          code;
  logic [7:0]    hf_cur, hs_cur;
  ans_pkg::pos_t pos_next, end_pos, back, len;
  logic          close;

  always_comb begin
    code     = (data_byte == ans_pkg::BYTE_ONE) && (zero_run_r >= ans_pkg::ZERO_RUN_CODE);
    pos_next = ans_pkg::pos_inc(pos_r);

    // header bytes captured from the first two payload words
    hf_cur = hdr_first_r;
    hs_cur = hdr_second_r;
    if (open_r && !code) begin
      if (pos_r == begin_r) begin
        hf_cur = data_byte;
      end else if ({1'b0, pos_r} == {1'b0, begin_r} + {{ans_pkg::POSITION_BITS{1'b0}}, 1'b1}) begin
        hs_cur = data_byte;
      end
    end

    back    = (zero_run_r == ans_pkg::ZERO_RUN_MAX) ? ans_pkg::pos_t'(3) : ans_pkg::pos_t'(2);
    end_pos = '0;
    if (code) begin
      end_pos = (pos_r >= back) ? pos_r - back : '0;
    end else if (stream_last) begin
      end_pos = pos_next;
    end
    close = open_r && (code || stream_last);
    len   = end_pos - begin_r;

    res_valid = accept && close && (end_pos >= begin_r) && (len >= ans_pkg::pos_t'(2));
    res.unit_offset  = ans_pkg::WORD_BITS'(begin_r);
    res.unit_length  = ans_pkg::WORD_BITS'(len);
    res.unit_type    = hf_cur[6:1];
    res.layer_num    = {hf_cur[0], hs_cur[7:3]};
    res.stream_final = stream_last;
  end

  always_comb begin
    pos_nxt        = pos_r;
    begin_nxt      = begin_r;
    zero_run_nxt   = zero_run_r;
    open_nxt       = open_r;
    hdr_first_nxt  = hdr_first_r;
    hdr_second_nxt = hdr_second_r;
    if (accept) begin
      if (stream_last) begin
        pos_nxt        = '0;
        begin_nxt      = '0;
        zero_run_nxt   = '0;
        open_nxt       = 1'b0;
        hdr_first_nxt  = '0;
        hdr_second_nxt = '0;
      end else begin
        pos_nxt = pos_next;
        if (code) begin
          open_nxt       = 1'b1;
          begin_nxt      = pos_next;
          hdr_first_nxt  = '0;
          hdr_second_nxt = '0;
        end else begin
          hdr_first_nxt  = hf_cur;
          hdr_second_nxt = hs_cur;
        end
        if (data_byte == ans_pkg::BYTE_ZERO) begin
          zero_run_nxt = (zero_run_r == ans_pkg::ZERO_RUN_MAX) ? zero_run_r : zero_run_r + 2'd1;
        end else begin
          zero_run_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      begin_r      <= '0;
      zero_run_r   <= '0;
      open_r       <= 1'b0;
      hdr_first_r  <= '0;
      hdr_second_r <= '0;
    end else begin
      pos_r        <= pos_nxt;
      begin_r      <= begin_nxt;
      zero_run_r   <= zero_run_nxt;
      open_r       <= open_nxt;
      hdr_first_r  <= hdr_first_nxt;
      hdr_second_r <= hdr_second_nxt;
    end
  end

  // an open unit never starts past the current position
  a_begin_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (begin_r <= pos_r))
    else $error("unit begin ahead of byte position");

  // the last word returns the scanner to its reset state
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && stream_last) |=> (!open_r && pos_r == '0 && zero_run_r == '0))
    else $error("state not cleared after last word");

  // a start code always leaves a unit open whose payload begins at the next word
  a_code_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && code && !stream_last) |=> (open_r && begin_r == pos_r))
    else $error("start code did not open unit");

endmodule
